FILE: design/polygon_edge_crossing_classifier_assert.svh
// Assertion macros for the polygon edge crossing classifier.
`ifndef POLYGON_EDGE_CROSSING_CLASSIFIER_ASSERT_SVH
`define POLYGON_EDGE_CROSSING_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PECC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pecc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PECC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pecc: next-cycle check failed");

`endif

FILE: design/pecc_pkg.sv
// Shared types and constants for the polygon edge crossing classifier.
`default_nettype none

package pecc_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FIELD_BITS     = 32;
  localparam int unsigned TOL_BITS       = 16;
  localparam int unsigned CFG_IDX_BITS   = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TEST_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TEST_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOL    = 2'd2;

  typedef enum logic [1:0] {
    CLS_OUT     = 2'd0,
    CLS_IN      = 2'd1,
    CLS_ON      = 2'd2,
    CLS_UNKNOWN = 2'd3
  } pecc_class_e;

  typedef struct packed {
    logic capture;   // take the input word
    logic diff_en;   // form offsets from the test point
    logic test_en;   // endpoint checks, load multiplier
    logic mul_step;  // one bit of the serial products
    logic comb_en;   // signed combine of the two products
    logic cmp_en;    // compare with tolerance bound
    logic emit;      // load result word, clear loop state
  } pecc_cmd_t;

  typedef struct packed {
    logic cross_req;
    logic last_edge;
    logic out_free;
  } pecc_status_t;

endpackage

`default_nettype wire

FILE: design/polygon_edge_crossing_classifier.sv
// Top level of the polygon edge crossing classifier.
`default_nettype none
`include "polygon_edge_crossing_classifier_assert.svh"

// Classifies a configured test point against one closed loop of straight
// edges, one edge per input word, by crossing parity along the horizontal
// line through the point. Coordinates are signed Q16.16 (COORD_BITS wide
// internally). An endpoint within tolerance of that line marks the loop as
// on the boundary (also near the point in x) or unknown; a clean crossing
// toggles a left or right parity bit, or marks on-boundary when it lands
// within tolerance of the point. The word flagged last_edge produces one
// result word: 0 out, 1 in, 2 on boundary, 3 unknown, and clears the loop
// state; other words produce nothing. The crossing test is exact: the
// interpolated offset is compared by cross-multiplication against
// tolerance*(|h0|+|h1|), with the three products formed by a bit-serial
// shift-add unit, one multiplier bit per cycle. An edge with no crossing
// passes through the diff, test and finish states; an edge whose ends
// straddle the line also passes the multiply, combine and compare states.
// One edge is in flight at a time. A finished result sits in an
// output register so the next edge can be accepted while it waits; only a
// second last_edge word stalls until that result is taken. Configuration
// writes (test_x, test_y, tolerance; other indexes ignored) are expected
// while the block is idle.
module polygon_edge_crossing_classifier import pecc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [FIELD_BITS-1:0]   cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [FIELD_BITS-1:0]   start_x_i,
  input  wire logic [FIELD_BITS-1:0]   start_y_i,
  input  wire logic [FIELD_BITS-1:0]   end_x_i,
  input  wire logic [FIELD_BITS-1:0]   end_y_i,
  input  wire logic                    last_edge_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   classification_o
);

  pecc_cmd_t    cmd;
  pecc_status_t status;

  pecc_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pecc_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .last_edge_i      (last_edge_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .classification_o (classification_o)
  );

  // one edge at a time: no new word the cycle after one is taken
  `PECC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // a result is only loaded for the closing edge of a loop, into a free slot
  `PECC_ASSERT_IMP(a_emit_on_last, clk_i, rst_ni, cmd.emit, status.last_edge && status.out_free)
  // result valid only rises after a load
  `PECC_ASSERT_IMP(a_valid_from_emit, clk_i, rst_ni, $rose(out_valid_o), $past(cmd.emit))

endmodule

`default_nettype wire

FILE: design/pecc_ctrl.sv
// Controller state machine for the polygon edge crossing classifier.
`default_nettype none

module pecc_ctrl import pecc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire pecc_status_t status_i,
  output pecc_cmd_t         cmd_o
);

  localparam int unsigned CW = $clog2(COORD_BITS);
  localparam logic [CW-1:0] MUL_LAST = CW'(COORD_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_TEST,
    S_MUL,
    S_COMB,
    S_CMP,
    S_FIN
  } state_e;

  state_e        state_q, state_d;
  logic          ready_q, ready_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          emit;

  assign emit = (state_q == S_FIN) && status_i.last_edge && status_i.out_free;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          state_d = S_DIFF;
          ready_d = 1'b0;
        end
      end
      S_DIFF: state_d = S_TEST;
      S_TEST: begin
        cnt_d   = '0;
        state_d = status_i.cross_req ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          state_d = S_COMB;
        end
      end
      S_COMB: state_d = S_CMP;
      S_CMP:  state_d = S_FIN;
      S_FIN: begin
        if (!status_i.last_edge || status_i.out_free) begin
          state_d = S_IDLE;
          ready_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = ready_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = in_valid_i && ready_q;
    cmd_o.diff_en  = (state_q == S_DIFF);
    cmd_o.test_en  = (state_q == S_TEST);
    cmd_o.mul_step = (state_q == S_MUL);
    cmd_o.comb_en  = (state_q == S_COMB);
    cmd_o.cmp_en   = (state_q == S_CMP);
    cmd_o.emit     = emit;
  end

endmodule

`default_nettype wire

FILE: design/pecc_datapath.sv
// Datapath: config registers, edge offsets, serial products, loop flags, result word.
`default_nettype none

module pecc_datapath import pecc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [FIELD_BITS-1:0]   cfg_data_i,
  input  wire logic [FIELD_BITS-1:0]   start_x_i,
  input  wire logic [FIELD_BITS-1:0]   start_y_i,
  input  wire logic [FIELD_BITS-1:0]   end_x_i,
  input  wire logic [FIELD_BITS-1:0]   end_y_i,
  input  wire logic                    last_edge_i,
  input  wire pecc_cmd_t               cmd_i,
  output pecc_status_t                 status_o,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   classification_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned MB = COORD_BITS;
  localparam int unsigned PW = 2 * MB + 1;
  // magnitude clamp, only active for very wide coordinates
  localparam logic [MB-1:0] SAT_LIM = MB'((65'd1 << 62) - 65'd1);

  function automatic logic [MB:0] coord_diff(input logic [FIELD_BITS-1:0] v,
                                             input logic [FIELD_BITS-1:0] t);
    logic [CB-1:0]    cv;
    logic [CB-1:0]    ct;
    logic signed [CB:0] d;
    logic [CB:0]      a;
    logic [MB-1:0]    m;
    cv = CB'(v);
    ct = CB'(t);
    d  = $signed({cv[CB-1], cv}) - $signed({ct[CB-1], ct});
    a  = d[CB] ? (CB+1)'(-d) : (CB+1)'(d);
    m  = a[MB-1:0];
    if (m > SAT_LIM) begin
      m = SAT_LIM;
    end
    return {d[CB], m};
  endfunction

  // config
  logic [FIELD_BITS-1:0] test_x_q, test_y_q;
  logic [TOL_BITS-1:0]   tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_x_q <= '0;
      test_y_q <= '0;
      tol_q    <= TOL_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEST_X: test_x_q <= cfg_data_i;
        CFG_TEST_Y: test_y_q <= cfg_data_i;
        CFG_TOL:    tol_q    <= cfg_data_i[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // captured edge
  logic [FIELD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                  last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sx_q   <= start_x_i;
      sy_q   <= start_y_i;
      ex_q   <= end_x_i;
      ey_q   <= end_y_i;
      last_q <= last_edge_i;
    end
  end

  // offsets from the test point, sign and magnitude
  logic [MB-1:0] dx0_q, h0_q, dx1_q, h1_q;
  logic          dx0_neg_q, h0_neg_q, dx1_neg_q, h1_neg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      {dx0_neg_q, dx0_q} <= coord_diff(sx_q, test_x_q);
      {h0_neg_q, h0_q}   <= coord_diff(sy_q, test_y_q);
      {dx1_neg_q, dx1_q} <= coord_diff(ex_q, test_x_q);
      {h1_neg_q, h1_q}   <= coord_diff(ey_q, test_y_q);
    end
  end

  // endpoint checks
  logic [MB-1:0] tol_ext;
  logic          clear0, clear1, near0, near1;
  logic [MB:0]   hsum;

  assign tol_ext = MB'(tol_q);
  assign clear0  = h0_q > tol_ext;
  assign clear1  = h1_q > tol_ext;
  assign near0   = dx0_q < tol_ext;
  assign near1   = dx1_q < tol_ext;
  assign hsum    = {1'b0, h0_q} + {1'b0, h1_q};

  // bit-serial products: dx0*|h1|, dx1*|h0|, tol*(|h0|+|h1|)
  logic [PW-1:0]       mc1_q, mc2_q, mcl_q;
  logic [MB-1:0]       mp1_q, mp2_q;
  logic [TOL_BITS-1:0] mpl_q;
  logic [PW-1:0]       acc1_q, acc2_q, accl_q;
  logic [PW-1:0]       s_q;
  logic                sneg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.test_en) begin
      mc1_q  <= PW'(dx0_q);
      mp1_q  <= h1_q;
      mc2_q  <= PW'(dx1_q);
      mp2_q  <= h0_q;
      mcl_q  <= PW'(hsum);
      mpl_q  <= tol_q;
      acc1_q <= '0;
      acc2_q <= '0;
      accl_q <= '0;
    end else if (cmd_i.mul_step) begin
      acc1_q <= acc1_q + (mp1_q[0] ? mc1_q : '0);
      acc2_q <= acc2_q + (mp2_q[0] ? mc2_q : '0);
      accl_q <= accl_q + (mpl_q[0] ? mcl_q : '0);
      mc1_q  <= mc1_q << 1;
      mc2_q  <= mc2_q << 1;
      mcl_q  <= mcl_q << 1;
      mp1_q  <= mp1_q >> 1;
      mp2_q  <= mp2_q >> 1;
      mpl_q  <= mpl_q >> 1;
    end
  end

  // signed sum of the two weighted offsets, kept as sign and magnitude
  always_ff @(posedge clk_i) begin
    if (cmd_i.comb_en) begin
      if (dx0_neg_q == dx1_neg_q) begin
        s_q    <= acc1_q + acc2_q;
        sneg_q <= dx0_neg_q;
      end else if (acc1_q >= acc2_q) begin
        s_q    <= acc1_q - acc2_q;
        sneg_q <= dx0_neg_q;
      end else begin
        s_q    <= acc2_q - acc1_q;
        sneg_q <= dx1_neg_q;
      end
    end
  end

  // loop flags
  logic on_edge_q, on_line_q, left_par_q, right_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_edge_q   <= 1'b0;
      on_line_q   <= 1'b0;
      left_par_q  <= 1'b0;
      right_par_q <= 1'b0;
    end else if (cmd_i.emit) begin
      on_edge_q   <= 1'b0;
      on_line_q   <= 1'b0;
      left_par_q  <= 1'b0;
      right_par_q <= 1'b0;
    end else if (cmd_i.test_en) begin
      // end point is only looked at when the start is clear
      if (!clear0) begin
        if (near0) on_edge_q <= 1'b1;
        else       on_line_q <= 1'b1;
      end else if (!clear1) begin
        if (near1) on_edge_q <= 1'b1;
        else       on_line_q <= 1'b1;
      end
    end else if (cmd_i.cmp_en) begin
      if (s_q > accl_q) begin
        if (sneg_q) left_par_q  <= !left_par_q;
        else        right_par_q <= !right_par_q;
      end else begin
        on_edge_q <= 1'b1;
      end
    end
  end

  // result word
  pecc_class_e cls_d;
  logic        out_valid_q;
  logic [1:0]  cls_q;

  always_comb begin
    if (on_edge_q)                       cls_d = CLS_ON;
    else if (on_line_q)                  cls_d = CLS_UNKNOWN;
    else if (left_par_q && right_par_q)  cls_d = CLS_IN;
    else if (!left_par_q && !right_par_q) cls_d = CLS_OUT;
    else                                 cls_d = CLS_UNKNOWN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      cls_q <= cls_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign classification_o = cls_q;

  always_comb begin
    status_o           = '0;
    status_o.cross_req = clear0 && clear1 && (h0_neg_q != h1_neg_q);
    status_o.last_edge = last_q;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the polygon edge crossing classifier.
`timescale 1ns / 1ps

module tb;
  import pecc_pkg::*;

  // Q16.16 coordinates used by the directed rows.
  localparam logic [FIELD_BITS-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [FIELD_BITS-1:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [FIELD_BITS-1:0] Q_TWO     = 32'h0002_0000;
  localparam logic [FIELD_BITS-1:0] Q_FIVE    = 32'h0005_0000;
  localparam logic [FIELD_BITS-1:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [FIELD_BITS-1:0] Q_MIN     = 32'h8000_0000;

  // The one index the block has no register behind; writes to it are dropped.
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  // Settle time after a drain: twice what the worst edge, one through the serial multiply, takes.
  localparam int SETTLE_CYCLES = 2 * (COORD_BITS_DEF + 6);
  localparam int PHASE_ITEMS   = 215;
  localparam int PLAN_ROWS     = 27;
  localparam int HOLD_CYCLES   = 600;

  typedef struct packed {
    logic [FIELD_BITS-1:0] sx;
    logic [FIELD_BITS-1:0] sy;
    logic [FIELD_BITS-1:0] ex;
    logic [FIELD_BITS-1:0] ey;
    logic                  last;
  } seg_t;

  typedef enum logic [0:0] {
    ROW_WRITE,
    ROW_SEG
  } row_kind_e;

  // One directed step: a register write (data in seg.sx) or an edge word,
  // optionally with the classification typed in by hand.
  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    seg_t                      seg;
    logic                      typed;
    pecc_class_e               want;
  } plan_row_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i   = '0;
  logic [FIELD_BITS-1:0]   cfg_data_i  = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [FIELD_BITS-1:0]   start_x_i   = '0;
  logic [FIELD_BITS-1:0]   start_y_i   = '0;
  logic [FIELD_BITS-1:0]   end_x_i     = '0;
  logic [FIELD_BITS-1:0]   end_y_i     = '0;
  logic                    last_edge_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [1:0]              classification_o;

  polygon_edge_crossing_classifier DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .last_edge_i      (last_edge_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .classification_o (classification_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: test point, tolerance and the four loop flags,
  // all at their reset values.
  // ---------------------------------------------------------------------
  logic [FIELD_BITS-1:0] cfg_x   = '0;
  logic [FIELD_BITS-1:0] cfg_y   = '0;
  logic [TOL_BITS-1:0]   cfg_tol = 16'd1;
  bit near_point, near_line, par_left, par_right;

  // Classifications still owed by the block, oldest first.
  pecc_class_e pending_class[$];

  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int unsigned mismatches   = 0;
  int unsigned taken        = 0;
  int          hold_left    = 0;

  plan_row_t plan [PLAN_ROWS];

  // Exact signed offset of a coordinate from the test point (33 bits).
  function automatic logic signed [32:0] rel(input logic [FIELD_BITS-1:0] v,
                                             input logic [FIELD_BITS-1:0] t);
    return $signed({v[31], v}) - $signed({t[31], t});
  endfunction

  function automatic logic [32:0] mag(input logic signed [32:0] d);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  // Endpoint within tolerance of the scan line: flags near-point or
  // on-line and reports the end as not clear.
  function automatic bit endpoint_clear(input logic signed [32:0] dx,
                                        input logic signed [32:0] h);
    if (mag(h) > 33'(cfg_tol)) return 1'b1;
    if (mag(dx) < 33'(cfg_tol)) near_point = 1'b1;
    else near_line = 1'b1;
    return 1'b0;
  endfunction

  // Folds one edge word into the loop flags. Returns 1 with the loop's
  // classification when the word closes the loop.
  function automatic bit classify_seg(input seg_t s, output pecc_class_e cls);
    logic signed [32:0]  dx0, h0, dx1, h1;
    logic signed [127:0] a0, a1, acc, lim;
    dx0 = rel(s.sx, cfg_x);
    h0  = rel(s.sy, cfg_y);
    dx1 = rel(s.ex, cfg_x);
    h1  = rel(s.ey, cfg_y);
    cls = CLS_OUT;
    // End point is only looked at when the start point is clear.
    if (endpoint_clear(dx0, h0)) begin
      if (endpoint_clear(dx1, h1) && (h0[32] != h1[32])) begin
        // Crossing offset times (|h0|+|h1|), compared without division.
        a0  = mag(h0);
        a1  = mag(h1);
        acc = dx0 * a1 + dx1 * a0;
        lim = (a0 + a1) * $signed({1'b0, cfg_tol});
        if ((acc < 0 ? -acc : acc) > lim) begin
          if (acc < 0) par_left = !par_left;
          else par_right = !par_right;
        end else begin
          near_point = 1'b1;
        end
      end
    end
    if (!s.last) return 1'b0;
    if (near_point) cls = CLS_ON;
    else if (near_line) cls = CLS_UNKNOWN;
    else if (par_left && par_right) cls = CLS_IN;
    else if (!par_left && !par_right) cls = CLS_OUT;
    else cls = CLS_UNKNOWN;
    near_point = 1'b0;
    near_line  = 1'b0;
    par_left   = 1'b0;
    par_right  = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table builders.
  // ---------------------------------------------------------------------
  function automatic plan_row_t seg_row(input logic [FIELD_BITS-1:0] sx, sy, ex, ey,
                                        input logic last);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_SEG;
    r.seg  = {sx, sy, ex, ey, last};
    r.want = CLS_OUT;
    return r;
  endfunction

  function automatic plan_row_t seg_row_want(input logic [FIELD_BITS-1:0] sx, sy, ex, ey,
                                             input logic last, input pecc_class_e want);
    plan_row_t r;
    r       = seg_row(sx, sy, ex, ey, last);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [FIELD_BITS-1:0] data);
    plan_row_t r;
    r        = '0;
    r.kind   = ROW_WRITE;
    r.idx    = idx;
    r.seg.sx = data;
    r.want   = CLS_OUT;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Random geometry around the current test point.
  // ---------------------------------------------------------------------
  // Within 3*tol+3 units of c: can land on the scan line or the point.
  function automatic logic [FIELD_BITS-1:0] near(input logic [FIELD_BITS-1:0] c);
    int span;
    span = 3 * int'(cfg_tol) + 3;
    return c + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Within about +-8 units of c: mostly clean crossings.
  function automatic logic [FIELD_BITS-1:0] spread(input logic [FIELD_BITS-1:0] c);
    return c + 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
  endfunction

  function automatic void pick_vertex(output logic [FIELD_BITS-1:0] x, y);
    case ($urandom_range(0, 9))
      0, 1: begin
        x = $urandom;
        y = $urandom;
      end
      2, 3, 4: begin
        x = near(cfg_x);
        y = near(cfg_y);
      end
      5, 6, 7: begin
        x = spread(cfg_x);
        y = spread(cfg_y);
      end
      8: begin
        x = spread(cfg_x);
        y = near(cfg_y);
      end
      default: begin
        x = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        y = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------
  // Stop offering words, wait out every owed result, then let any
  // non-final edge still in the datapath finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_class.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [FIELD_BITS-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TEST_X: cfg_x   = val;
      CFG_TEST_Y: cfg_y   = val;
      CFG_TOL:    cfg_tol = val[TOL_BITS-1:0];
      default: ;
    endcase
  endtask

  // Offer one edge word; on acceptance fold it into the shadow state.
  // Valid is only dropped when a gap is taken, so back-to-back words keep
  // it high with a single assignment per edge.
  task automatic send_seg(input seg_t s, input bit typed, input pecc_class_e want);
    pecc_class_e cls;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_valid_i  <= 1'b1;
    start_x_i   <= s.sx;
    start_y_i   <= s.sy;
    end_x_i     <= s.ex;
    end_y_i     <= s.ey;
    last_edge_i <= s.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (classify_seg(s, cls)) pending_class.push_back(typed ? want : cls);
  endtask

  // Mostly closed loops of 1..8 random vertices; the rest is loose noise
  // words and loops whose closing edge misses the first vertex.
  task automatic run_random(input int n_items);
    logic [FIELD_BITS-1:0] vx [8];
    logic [FIELD_BITS-1:0] vy [8];
    seg_t s;
    int   sent;
    int   len;
    bit   broken;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        s = {$urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1))};
        send_seg(s, 1'b0, CLS_OUT);
        sent++;
      end else begin
        len    = $urandom_range(1, 8);
        broken = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++) pick_vertex(vx[i], vy[i]);
        for (int i = 0; i < len; i++) begin
          s.sx   = vx[i];
          s.sy   = vy[i];
          s.ex   = vx[(i + 1) % len];
          s.ey   = vy[(i + 1) % len];
          s.last = (i == len - 1);
          if (broken && s.last) pick_vertex(s.ex, s.ey);
          send_seg(s, 1'b0, CLS_OUT);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: checks every accepted result word against the oldest
  // owed classification and drives out_ready. Twice in the run it holds
  // ready low for a long stretch so the output register fills and the
  // next loop-closing word backs up into the input.
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [1:0] want,
                               input logic [1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin : sink
    pecc_class_e want_cls;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_class.size() == 0) begin
          flag_mismatch("classification word with nothing owed", 2'bxx, classification_o);
        end else begin
          want_cls = pending_class.pop_front();
          if (classification_o !== want_cls)
            flag_mismatch("classification mismatch", want_cls, classification_o);
        end
        taken++;
        if (taken == 40 || taken == 160) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    plan = '{
      // after reset: point at origin, tolerance 1; no crossing -> out
      seg_row_want(32'd0, Q_ONE, Q_ONE, Q_TWO, 1'b1, CLS_OUT),
      // unit square around the point -> in
      seg_row(Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_NEG_ONE, 1'b0),
      seg_row(Q_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, 1'b0),
      seg_row(Q_ONE, Q_ONE, Q_NEG_ONE, Q_ONE, 1'b0),
      seg_row_want(Q_NEG_ONE, Q_ONE, Q_NEG_ONE, Q_NEG_ONE, 1'b1, CLS_IN),
      // start point on the test point
      seg_row_want(32'd0, 32'd0, Q_ONE, Q_ONE, 1'b1, CLS_ON),
      // start on the line away from the point: end (on the point) not looked at
      seg_row_want(Q_FIVE, 32'd0, 32'd0, 32'd0, 1'b1, CLS_UNKNOWN),
      // end point on the test point
      seg_row_want(Q_ONE, Q_ONE, 32'd0, 32'd0, 1'b1, CLS_ON),
      // single crossing to the right: odd/even parity mix
      seg_row_want(Q_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, 1'b1, CLS_UNKNOWN),
      // crossing right through the point
      seg_row_want(32'd0, Q_NEG_ONE, 32'd0, Q_ONE, 1'b1, CLS_ON),
      // full-range coordinates
      seg_row(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 1'b1),
      seg_row(Q_MAX, Q_MIN, Q_MAX, Q_MAX, 1'b0),
      seg_row(Q_MIN, Q_MAX, Q_MIN, Q_MIN, 1'b1),
      seg_row_want(Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1, CLS_OUT),
      // altitude and x offset both exactly at the tolerance
      seg_row(32'd1, 32'd1, Q_ONE, Q_ONE, 1'b1),
      // on-line flag survives later clean crossings
      seg_row(Q_FIVE, 32'd0, Q_ONE, Q_ONE, 1'b0),
      seg_row(Q_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, 1'b0),
      seg_row(Q_NEG_ONE, Q_ONE, Q_NEG_ONE, Q_NEG_ONE, 1'b1),
      // zero tolerance: endpoint on point counts as on-line only,
      // exact crossing at the point still counts as on-boundary
      write_row(CFG_TOL, 32'd0),
      seg_row_want(32'd0, 32'd0, Q_ONE, Q_ONE, 1'b1, CLS_UNKNOWN),
      seg_row_want(32'd0, Q_NEG_ONE, 32'd0, Q_ONE, 1'b1, CLS_ON),
      // moved point, widest tolerance (upper data bits must be dropped)
      write_row(CFG_TEST_X, Q_ONE),
      write_row(CFG_TEST_Y, Q_ONE),
      write_row(CFG_TOL, 32'hFFFF_FFFF),
      seg_row(32'd0, 32'd0, Q_TWO, Q_TWO, 1'b1),
      // write to the unused index leaves everything as it was
      write_row(CFG_UNUSED, 32'd0),
      seg_row(Q_TWO, 32'd0, Q_TWO, Q_TWO, 1'b1)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 11;
    snk_idle_pct = 71;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].seg.sx);
      else send_seg(plan[i].seg, plan[i].typed, plan[i].want);
    end

    // Random phases. Each one starts with a full drain (sender paused until
    // nothing is owed), then a new test point and tolerance.
    for (int p = 0; p < 6; p++) begin
      src_idle_pct = (p < 2) ? 11 : (p < 4) ? 71 : 0;
      snk_idle_pct = (p < 2) ? 71 : (p < 4) ? 11 : 0;
      case (p)
        0: begin
          write_reg(CFG_TEST_X, 32'd0);
          write_reg(CFG_TEST_Y, 32'd0);
          write_reg(CFG_TOL, 32'd1);
        end
        1: begin
          write_reg(CFG_TEST_X, Q_MIN);
          write_reg(CFG_TEST_Y, Q_MAX);
          write_reg(CFG_TOL, {16'($urandom), 16'hFFFF});
        end
        2: begin
          write_reg(CFG_TEST_X, $urandom);
          write_reg(CFG_TEST_Y, $urandom);
          write_reg(CFG_TOL, {16'($urandom), 16'h0000});
        end
        3: begin
          write_reg(CFG_TEST_X, Q_MAX);
          write_reg(CFG_TEST_Y, Q_MIN);
          write_reg(CFG_TOL, $urandom);
        end
        4: begin
          write_reg(CFG_TEST_X, $urandom);
          write_reg(CFG_TEST_Y, $urandom);
          write_reg(CFG_TOL, 32'($urandom_range(0, 15)));
          write_reg(CFG_UNUSED, $urandom);
        end
        default: begin
          write_reg(CFG_TEST_X, $urandom);
          write_reg(CFG_TEST_Y, $urandom);
          write_reg(CFG_TOL, 32'h0000_FFFF);
        end
      endcase
      run_random(PHASE_ITEMS);
    end

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/pecc_pkg.sv
design/pecc_ctrl.sv
design/pecc_datapath.sv
design/polygon_edge_crossing_classifier.sv
tb/tb.sv
